### rtl/cfp_pkg.sv
package cfp_pkg;

   localparam int CFG_INDEX_W = 3;
   localparam int CFG_DATA_W = 9;
   localparam int PAN_W = 9;
   localparam int POS_W = 5;

   localparam logic [7:0] HDR_FIRST = 8'hAA;
   localparam logic [7:0] HDR_SECOND = 8'h55;
   localparam logic [POS_W-1:0] POS_CRC_LOW = 5'd14;
   localparam logic [POS_W-1:0] POS_CRC_HIGH = 5'd15;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic signed [16:0] PAN_ROUND = 17'sd50;
   localparam logic [12:0] PAN_RECIP = 13'd5243;
   localparam int PAN_SHIFT = 19;

   localparam int DEF_QUEUE_DEPTH = 4;
   localparam int DEF_RESULT_DEPTH = 2;

   typedef enum logic [CFG_INDEX_W-1:0] {
      REG_PAN_MIN   = 3'd0,
      REG_PAN_MAX   = 3'd1,
      REG_AUTO_MASK = 3'd2,
      REG_ESTOP_MASK = 3'd3,
      REG_VALID_MASK = 3'd4,
      REG_V2_MASK   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [PAN_W-1:0] pan_min;
      logic signed [PAN_W-1:0] pan_max;
      logic [7:0] auto_mask;
      logic [7:0] estop_mask;
      logic [7:0] valid_mask;
      logic [7:0] v2_mask;
   } cfg_type;

   typedef struct packed {
      logic [7:0] sequence_byte;
      logic [7:0] flags;
      logic [15:0] vx;
      logic [15:0] vy;
      logic [15:0] omega;
      logic [15:0] pan_raw;
      logic [31:0] update_ms;
   } frame_type;

   typedef struct packed {
      logic [7:0] sequence_res;
      logic auto_select;
      logic estop;
      logic cmd_ok;
      logic pan_whole_deg;
      logic signed [15:0] vx_milli;
      logic signed [15:0] vy_milli;
      logic signed [15:0] omega_milli;
      logic signed [PAN_W-1:0] pan_deg;
      logic [31:0] update_ms;
   } result_type;

endpackage

### rtl/cfp_fifo.sv
module cfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == DEPTH_CNT);
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/cfp_front.sv
module cfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   input  logic [31:0]         now_ms,
   output logic                frame_push,
   output cfp_pkg::frame_type  frame_data
);

   import cfp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0] crc_low_ff;
   logic [7:0] data_ff [2:11];
   logic [15:0] crc_next;
   logic [15:0] crc_restart;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   assign crc_next = crc_feed(crc_ff, rx_byte);
   assign crc_restart = crc_feed(CRC_INIT, HDR_FIRST);

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      frame_push = 1'b0;
      if (accept) begin
         if (pos_ff == '0) begin
            if (rx_byte == HDR_FIRST) begin
               pos_in = 5'd1;
               crc_in = crc_restart;
            end
         end else if (pos_ff == 5'd1) begin
            if (rx_byte == HDR_SECOND) begin
               pos_in = 5'd2;
               crc_in = crc_next;
            end else if (rx_byte == HDR_FIRST) begin
               pos_in = 5'd1;
               crc_in = crc_restart;
            end else begin
               pos_in = '0;
            end
         end else if (pos_ff < POS_CRC_LOW) begin
            pos_in = pos_ff + 1'b1;
            crc_in = crc_next;
         end else if (pos_ff == POS_CRC_LOW) begin
            pos_in = POS_CRC_HIGH;
         end else begin
            pos_in = '0;
            frame_push = ({rx_byte, crc_low_ff} == crc_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 2; i <= 11; i++) begin
            if (pos_ff == POS_W'(i)) begin
               data_ff[i] <= rx_byte;
            end
         end
         if (pos_ff == POS_CRC_LOW) begin
            crc_low_ff <= rx_byte;
         end
      end
   end

   always_comb begin
      frame_data.sequence_byte = data_ff[2];
      frame_data.flags = data_ff[3];
      frame_data.vx = {data_ff[5], data_ff[4]};
      frame_data.vy = {data_ff[7], data_ff[6]};
      frame_data.omega = {data_ff[9], data_ff[8]};
      frame_data.pan_raw = {data_ff[11], data_ff[10]};
      frame_data.update_ms = now_ms;
   end

endmodule

### rtl/cfp_back.sv
module cfp_back (
   input  logic                clock,
   input  logic                reset,
   input  cfp_pkg::cfg_type    cfg,
   input  logic                frame_empty,
   input  cfp_pkg::frame_type  frame_data,
   output logic                frame_pop,
   input  logic                result_full,
   output logic                result_push,
   output cfp_pkg::result_type result_data
);

   import cfp_pkg::*;

   logic s1_valid_ff, s1_valid_in;
   frame_type s1_rec_ff;
   logic s1_neg_ff;
   logic [28:0] s1_prod_ff;

   logic signed [16:0] rounded;
   logic in_neg;
   logic [15:0] in_mag;
   logic [28:0] in_prod;

   logic v2;
   logic [9:0] quot;
   logic signed [16:0] ang;
   logic signed [16:0] lo;
   logic signed [16:0] hi;
   logic signed [16:0] clamped;

   assign frame_pop = !frame_empty && (!s1_valid_ff || !result_full);
   assign result_push = s1_valid_ff && !result_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (frame_pop) begin
         s1_valid_in = 1'b1;
      end else if (result_push) begin
         s1_valid_in = 1'b0;
      end
   end

   assign rounded = $signed({frame_data.pan_raw[15], frame_data.pan_raw}) + PAN_ROUND;
   assign in_neg = rounded[16];
   assign in_mag = in_neg ? 16'(-rounded) : rounded[15:0];
   assign in_prod = 29'(in_mag) * 29'(PAN_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop) begin
         s1_rec_ff <= frame_data;
         s1_neg_ff <= in_neg;
         s1_prod_ff <= in_prod;
      end
   end

   assign v2 = |(s1_rec_ff.flags & cfg.v2_mask);
   assign quot = s1_prod_ff[28:PAN_SHIFT];
   assign lo = $signed({{8{cfg.pan_min[PAN_W-1]}}, cfg.pan_min});
   assign hi = $signed({{8{cfg.pan_max[PAN_W-1]}}, cfg.pan_max});

   always_comb begin
      if (v2) begin
         ang = $signed({s1_rec_ff.pan_raw[15], s1_rec_ff.pan_raw});
      end else if (s1_neg_ff) begin
         ang = -$signed(17'(quot));
      end else begin
         ang = $signed(17'(quot));
      end
      if (ang < lo) begin
         clamped = lo;
      end else if (ang > hi) begin
         clamped = hi;
      end else begin
         clamped = ang;
      end
   end

   always_comb begin
      result_data.sequence_res = s1_rec_ff.sequence_byte;
      result_data.auto_select = |(s1_rec_ff.flags & cfg.auto_mask);
      result_data.estop = |(s1_rec_ff.flags & cfg.estop_mask);
      result_data.cmd_ok = |(s1_rec_ff.flags & cfg.valid_mask);
      result_data.pan_whole_deg = v2;
      result_data.vx_milli = s1_rec_ff.vx;
      result_data.vy_milli = s1_rec_ff.vy;
      result_data.omega_milli = s1_rec_ff.omega;
      result_data.pan_deg = clamped[PAN_W-1:0];
      result_data.update_ms = s1_rec_ff.update_ms;
   end

endmodule

### rtl/command_frame_parser_crc16_top.sv
// Serial command frame parser. One received byte is a transaction on the req_ side, so
// bytes may arrive on every clock while req_full is low; the running CRC-16 update and
// the byte store are done as each byte is taken. A frame is the header 0xAA 0x55 followed by
// fourteen more bytes, with a little-endian CRC-16/CCITT-FALSE over the first fourteen in the
// last two. Each good frame is placed in a frame queue of QUEUE_DEPTH entries, and req_full is
// high only while that queue is full; bad frames are dropped silently. The back end scales
// the pan angle (a reciprocal multiply for the centidegree form, else whole degrees pass
// through), clamps it to the configured limits and writes it into a RESULT_DEPTH-entry
// result queue; a result goes from the frame queue through the back-end register into
// that queue, and one result can leave per cycle while the queue is not empty. Configuration
// writes take effect at once and should be made only while no frame is in flight.
module command_frame_parser_crc16_top #(
   parameter int QUEUE_DEPTH = cfp_pkg::DEF_QUEUE_DEPTH,
   parameter int RESULT_DEPTH = cfp_pkg::DEF_RESULT_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_rx_byte,
   input  logic [31:0]                          req_now_ms,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [7:0]                           rsp_sequence_res,
   output logic                                 rsp_auto_select,
   output logic                                 rsp_estop,
   output logic                                 rsp_cmd_ok,
   output logic                                 rsp_pan_whole_deg,
   output logic signed [15:0]                   rsp_vx_milli,
   output logic signed [15:0]                   rsp_vy_milli,
   output logic signed [15:0]                   rsp_omega_milli,
   output logic signed [cfp_pkg::PAN_W-1:0]     rsp_pan_deg,
   output logic [31:0]                          rsp_update_ms,
   input  logic                                 csr_we,
   input  logic [cfp_pkg::CFG_INDEX_W-1:0]      csr_index,
   input  logic [cfp_pkg::CFG_DATA_W-1:0]       csr_wdata
);

   import cfp_pkg::*;

   localparam int FRAME_W = $bits(frame_type);
   localparam int RESULT_W = $bits(result_type);

   cfg_type cfg_ff, cfg_in;
   logic req_accept;
   logic frame_push;
   frame_type front_frame;
   logic frame_full;
   logic frame_empty;
   logic frame_pop;
   logic [FRAME_W-1:0] queue_head;
   frame_type back_frame;
   logic result_full;
   logic result_push;
   result_type back_result;
   logic [RESULT_W-1:0] result_head;
   result_type rsp_result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_PAN_MIN: cfg_in.pan_min = csr_wdata;
            REG_PAN_MAX: cfg_in.pan_max = csr_wdata;
            REG_AUTO_MASK: cfg_in.auto_mask = csr_wdata[7:0];
            REG_ESTOP_MASK: cfg_in.estop_mask = csr_wdata[7:0];
            REG_VALID_MASK: cfg_in.valid_mask = csr_wdata[7:0];
            REG_V2_MASK: cfg_in.v2_mask = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pan_min <= 9'sd0;
         cfg_ff.pan_max <= 9'sd180;
         cfg_ff.auto_mask <= 8'd1;
         cfg_ff.estop_mask <= 8'd2;
         cfg_ff.valid_mask <= 8'd4;
         cfg_ff.v2_mask <= 8'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = frame_full;
   assign req_accept = req_push && !frame_full;

   cfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .rx_byte    (req_rx_byte),
      .now_ms     (req_now_ms),
      .frame_push (frame_push),
      .frame_data (front_frame)
   );

   cfp_fifo #(
      .WIDTH (FRAME_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_frame_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (front_frame),
      .full      (frame_full),
      .pop       (frame_pop),
      .pop_data  (queue_head),
      .empty     (frame_empty)
   );

   assign back_frame = queue_head;

   cfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frame_empty (frame_empty),
      .frame_data  (back_frame),
      .frame_pop   (frame_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result_data (back_result)
   );

   cfp_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (result_head),
      .empty     (rsp_empty)
   );

   assign rsp_result = result_head;
   assign rsp_sequence_res = rsp_result.sequence_res;
   assign rsp_auto_select = rsp_result.auto_select;
   assign rsp_estop = rsp_result.estop;
   assign rsp_cmd_ok = rsp_result.cmd_ok;
   assign rsp_pan_whole_deg = rsp_result.pan_whole_deg;
   assign rsp_vx_milli = rsp_result.vx_milli;
   assign rsp_vy_milli = rsp_result.vy_milli;
   assign rsp_omega_milli = rsp_result.omega_milli;
   assign rsp_pan_deg = rsp_result.pan_deg;
   assign rsp_update_ms = rsp_result.update_ms;

endmodule

### bench/command_frame_parser_crc16_top_test.sv
module command_frame_parser_crc16_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cfp_pkg::*;

   localparam int FRAME_BYTES = 16;
   localparam int ROUND_HALF = 50;
   localparam int CENTI_PER_DEG = 100;
   localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

   typedef enum logic [1:0] {
      LEAD_NONE,
      LEAD_REPEAT_HDR,
      LEAD_BAD_HDR
   } lead_kind_type;

   typedef struct {
      lead_kind_type lead;
      logic [7:0]  seq;
      logic [7:0]  flags;
      logic [15:0] vx;
      logic [15:0] vy;
      logic [15:0] omega;
      logic [15:0] pan_raw;
      bit          bad_crc;
      logic [31:0] stamp;
      bit          pan_typed;
      int          pan_exp;
   } frame_row_type;

   // Typed pan values hold for the power-on register settings.
   frame_row_type dir_rows[6] = '{
      '{LEAD_NONE,       8'h00, 8'h0F, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 1'b0,
        32'h0000_0000, 1'b1, 180},
      '{LEAD_NONE,       8'hFF, 8'hFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 1'b0,
        32'hFFFF_FFFF, 1'b1, 0},
      '{LEAD_REPEAT_HDR, 8'h5A, 8'h00, 16'h1234, 16'hEDCC, 16'h0001, 16'h2359, 1'b0,
        32'h0000_0001, 1'b1, 90},
      '{LEAD_BAD_HDR,    8'hA5, 8'h04, 16'h0000, 16'h0000, 16'h8001, 16'hFF6A, 1'b0,
        32'h7FFF_FFFF, 1'b1, 0},
      '{LEAD_NONE,       8'h11, 8'h0F, 16'h00FF, 16'hFF00, 16'h5555, 16'h005A, 1'b1,
        32'hAAAA_5555, 1'b0, 0},
      '{LEAD_NONE,       8'h80, 8'h08, 16'hAAAA, 16'h5555, 16'h7FFF, 16'h005A, 1'b0,
        32'h8000_0000, 1'b1, 90}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_rx_byte = 8'h00;
   logic [31:0] req_now_ms = 32'h0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [7:0] rsp_sequence_res;
   logic rsp_auto_select;
   logic rsp_estop;
   logic rsp_cmd_ok;
   logic rsp_pan_whole_deg;
   logic signed [15:0] rsp_vx_milli;
   logic signed [15:0] rsp_vy_milli;
   logic signed [15:0] rsp_omega_milli;
   logic signed [PAN_W-1:0] rsp_pan_deg;
   logic [31:0] rsp_update_ms;
   logic csr_we = 1'b0;
   logic [CFG_INDEX_W-1:0] csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;

   logic signed [PAN_W-1:0] pan_min_cfg = 9'sd0;
   logic signed [PAN_W-1:0] pan_max_cfg = 9'sd180;
   logic [7:0] auto_mask_cfg = 8'h01;
   logic [7:0] estop_mask_cfg = 8'h02;
   logic [7:0] valid_mask_cfg = 8'h04;
   logic [7:0] v2_mask_cfg = 8'h08;

   int frame_pos = 0;
   logic [7:0] frame_buf[14];
   logic [7:0] crc_low_seen = 8'h00;
   logic [15:0] frame_crc = CRC_INIT;

   result_type expected_results[$];
   bit typed_pan_valid = 1'b0;
   logic [PAN_W-1:0] typed_pan = '0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   int rx_hold_request = 0;
   int mismatch_count = 0;
   int bytes_sent = 0;
   int frames_predicted = 0;
   int results_checked = 0;
   int full_stall_cycles = 0;

   command_frame_parser_crc16_top u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic [31:0] stamp,
                                     output result_type res);
      int raw_pan;
      int ang;
      logic [7:0] fl;
      res = '0;
      if (frame_pos == 0) begin
         if (b == HDR_FIRST) begin
            frame_buf[0] = b;
            frame_crc = crc16_next(CRC_INIT, b);
            frame_pos = 1;
         end
         return 1'b0;
      end
      if (frame_pos == 1) begin
         if (b == HDR_SECOND) begin
            frame_buf[1] = b;
            frame_crc = crc16_next(frame_crc, b);
            frame_pos = 2;
         end else if (b == HDR_FIRST) begin
            frame_buf[0] = b;
            frame_crc = crc16_next(CRC_INIT, b);
         end else begin
            frame_pos = 0;
         end
         return 1'b0;
      end
      if (frame_pos < POS_CRC_LOW) begin
         frame_buf[frame_pos] = b;
         frame_crc = crc16_next(frame_crc, b);
         frame_pos++;
         return 1'b0;
      end
      if (frame_pos == POS_CRC_LOW) begin
         crc_low_seen = b;
         frame_pos++;
         return 1'b0;
      end
      frame_pos = 0;
      if ({b, crc_low_seen} != frame_crc) return 1'b0;
      fl = frame_buf[3];
      res.sequence_res = frame_buf[2];
      res.auto_select = |(fl & auto_mask_cfg);
      res.estop = |(fl & estop_mask_cfg);
      res.cmd_ok = |(fl & valid_mask_cfg);
      res.pan_whole_deg = |(fl & v2_mask_cfg);
      res.vx_milli = {frame_buf[5], frame_buf[4]};
      res.vy_milli = {frame_buf[7], frame_buf[6]};
      res.omega_milli = {frame_buf[9], frame_buf[8]};
      raw_pan = int'($signed({frame_buf[11], frame_buf[10]}));
      ang = res.pan_whole_deg ? raw_pan : (raw_pan + ROUND_HALF) / CENTI_PER_DEG;
      if (ang < int'(pan_min_cfg)) ang = int'(pan_min_cfg);
      else if (ang > int'(pan_max_cfg)) ang = int'(pan_max_cfg);
      res.pan_deg = ang[PAN_W-1:0];
      res.update_ms = stamp;
      return 1'b1;
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic [31:0] stamp);
      result_type res;
      int gap;
      req_push <= 1'b1;
      req_rx_byte <= b;
      req_now_ms <= stamp;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      if (parse_byte(b, stamp, res)) begin
         if (typed_pan_valid) res.pan_deg = typed_pan;
         expected_results.push_back(res);
         frames_predicted++;
      end
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(input lead_kind_type lead, input logic [7:0] seq, flags,
                             input logic [15:0] vx, vy, omega, pan, input bit bad_crc,
                             input int cut, input logic [31:0] stamp, input bit stamp_random);
      logic [7:0] fb[FRAME_BYTES];
      logic [15:0] crc;
      logic [7:0] junk;
      fb[0] = HDR_FIRST;
      fb[1] = HDR_SECOND;
      fb[2] = seq;
      fb[3] = flags;
      {fb[5], fb[4]} = vx;
      {fb[7], fb[6]} = vy;
      {fb[9], fb[8]} = omega;
      {fb[11], fb[10]} = pan;
      crc = CRC_INIT;
      for (int i = 0; i < POS_CRC_LOW; i++) crc = crc16_next(crc, fb[i]);
      fb[14] = crc[7:0];
      fb[15] = crc[15:8] ^ {7'd0, bad_crc};
      if (lead == LEAD_REPEAT_HDR) begin
         push_byte(HDR_FIRST, stamp_random ? $urandom : stamp);
      end else if (lead == LEAD_BAD_HDR) begin
         do junk = 8'($urandom); while (junk == HDR_FIRST || junk == HDR_SECOND);
         push_byte(HDR_FIRST, stamp_random ? $urandom : stamp);
         push_byte(junk, stamp_random ? $urandom : stamp);
      end
      for (int i = 0; i < cut; i++) push_byte(fb[i], stamp_random ? $urandom : stamp);
   endtask

   task automatic send_random_frame();
      int kind;
      int cut;
      lead_kind_type lead;
      logic [15:0] pan;
      kind = $urandom_range(0, 99);
      lead = LEAD_NONE;
      cut = FRAME_BYTES;
      if (kind < 7) lead = LEAD_REPEAT_HDR;
      else if (kind < 13) lead = LEAD_BAD_HDR;
      else if (kind < 18) cut = $urandom_range(3, 13);
      else if (kind < 24) repeat ($urandom_range(1, 5)) push_byte(8'($urandom), $urandom);
      case ($urandom_range(0, 2))
         0: pan = 16'($urandom_range(0, 400)) - 16'd200;
         1: pan = 16'($urandom_range(0, 40000)) - 16'd20000;
         default: pan = 16'($urandom);
      endcase
      send_frame(lead, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), pan, kind >= 24 && kind < 31, cut, 32'h0, 1'b1);
   endtask

   task automatic drive_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_PAN_MIN:    pan_min_cfg = val;
         REG_PAN_MAX:    pan_max_cfg = val;
         REG_AUTO_MASK:  auto_mask_cfg = val[7:0];
         REG_ESTOP_MASK: estop_mask_cfg = val[7:0];
         REG_VALID_MASK: valid_mask_cfg = val[7:0];
         REG_V2_MASK:    v2_mask_cfg = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [CFG_DATA_W-1:0] pmin, pmax, am, em, vm, v2m,
                             input bit spare);
      drive_reg(REG_PAN_MIN, pmin);
      drive_reg(REG_PAN_MAX, pmax);
      drive_reg(REG_AUTO_MASK, am);
      drive_reg(REG_ESTOP_MASK, em);
      drive_reg(REG_VALID_MASK, vm);
      drive_reg(REG_V2_MASK, v2m);
      if (spare) begin
         drive_reg(REG_SPARE_A, 9'h1FF);
         drive_reg(REG_SPARE_B, 9'h0AA);
      end
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_push <= 1'b0;
      while (expected_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_push && req_full) full_stall_cycles++;
         if (rsp_pop && !rsp_empty) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               $error("result transaction with none expected, sequence_res %0d",
                      rsp_sequence_res);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("sequence_res", want.sequence_res, rsp_sequence_res);
               check_field("auto_select", want.auto_select, rsp_auto_select);
               check_field("estop", want.estop, rsp_estop);
               check_field("cmd_ok", want.cmd_ok, rsp_cmd_ok);
               check_field("pan_whole_deg", want.pan_whole_deg, rsp_pan_whole_deg);
               check_field("vx_milli", want.vx_milli, rsp_vx_milli);
               check_field("vy_milli", want.vy_milli, rsp_vy_milli);
               check_field("omega_milli", want.omega_milli, rsp_omega_milli);
               check_field("pan_deg", want.pan_deg, rsp_pan_deg);
               check_field("update_ms", want.update_ms, rsp_update_ms);
            end
         end
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rx_hold_request > 0) begin
            stall_left = rx_hold_request;
            rx_hold_request = 0;
         end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      int phase_start;
      int budget;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         typed_pan_valid = dir_rows[i].pan_typed;
         typed_pan = dir_rows[i].pan_exp[PAN_W-1:0];
         send_frame(dir_rows[i].lead, dir_rows[i].seq, dir_rows[i].flags, dir_rows[i].vx,
                    dir_rows[i].vy, dir_rows[i].omega, dir_rows[i].pan_raw,
                    dir_rows[i].bad_crc, FRAME_BYTES, dir_rows[i].stamp, 1'b0);
      end
      typed_pan_valid = 1'b0;
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            1: set_config(9'(-180), 9'(180), 9'($urandom_range(1, 255)),
                          9'($urandom_range(1, 255)), 9'($urandom_range(1, 255)),
                          9'($urandom_range(1, 255)), 1'b0);
            2: set_config(9'(50), 9'(-50), 9'h000, 9'h000, 9'h000, 9'h000, 1'b1);
            3: set_config(9'(-180), 9'(-180), 9'h1FF, 9'h180, 9'h101, 9'h1F0, 1'b0);
            4: set_config(9'($urandom_range(0, 360) - 180), 9'($urandom_range(0, 360) - 180),
                          9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
                          9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)), 1'b0);
            5: set_config(9'(180), 9'(180), 9'(1 << $urandom_range(0, 7)),
                          9'(1 << $urandom_range(0, 7)), 9'(1 << $urandom_range(0, 7)),
                          9'(1 << $urandom_range(0, 7)), 1'b0);
            default: ;
         endcase
         // The first phase sends back to back into a stalled receiver to fill the queues.
         if (p == 0) rx_hold_request = 400;
         tx_steady = (p == 0) || (p == 4);
         rx_steady = (p == 4);
         budget = (p == 0) ? 140 : 75;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < budget) send_random_frame();
         tx_steady = 1'b0;
         rx_steady = 1'b0;
         drain();
      end

      if (expected_results.size() != 0) begin
         $error("%0d expected frame results never arrived", expected_results.size());
         mismatch_count++;
      end
      $display("Sent %0d bytes over six register settings, checked %0d of %0d frame results.",
               bytes_sent, results_checked, frames_predicted);
      $display("Input was held off by a full queue for %0d cycles.", full_stall_cycles);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
rtl/cfp_pkg.sv
rtl/cfp_fifo.sv
rtl/cfp_front.sv
rtl/cfp_back.sv
rtl/command_frame_parser_crc16_top.sv
bench/command_frame_parser_crc16_top_test.sv
